/* src/chain_move_constraint_checker_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chain move constraint checker
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAIN_MOVE_CONSTRAINT_CHECKER_UNIT_ASSERT_SVH
`define CHAIN_MOVE_CONSTRAINT_CHECKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CMCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmcc assertion failed");
`define CMCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmcc assertion failed");
`else
`define CMCC_ASSERT_IMPL(lbl, ante, cons)
`define CMCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/cmcc_pkg.sv */
// ----------------------------------------------------------------------------
// cmcc_pkg
// Sizes, register codes and shared types of the chain move constraint checker.
// ----------------------------------------------------------------------------
package cmcc_pkg;

  localparam int MAX_MONOMERS = 64;
  localparam int COORD_W      = 16;

  localparam int AW     = (MAX_MONOMERS > 1) ? $clog2(MAX_MONOMERS) : 1;
  localparam int CNT_W  = $clog2(MAX_MONOMERS + 1);
  localparam int POS_W  = 3 * COORD_W;

  localparam int IDX_W  = 6;
  localparam int FLD_W  = 16;
  localparam int CUT_W  = 16;
  localparam int COS_W  = 16;
  localparam int LEN_W  = 7;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 16;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int CSQ_W  = 2 * CUT_W;
  localparam int CMP_W  = ((SUM_W > CSQ_W) ? SUM_W : CSQ_W) + 4;
  localparam int BSQ_W  = 2 * COS_W - 1;
  localparam int SHL_W  = BSQ_W - 1;

  localparam int MA_W   = 2 * SUM_W;
  localparam int MB_W   = (SUM_W > BSQ_W) ? SUM_W : BSQ_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int DIG_W  = 8;
  localparam int NDIG   = (MB_W + DIG_W - 1) / DIG_W;
  localparam int BR_W   = NDIG * DIG_W;
  localparam int MCNT_W = $clog2(NDIG + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_CUTOFF    = 2'd0,
    REG_BOND_COS  = 2'd1,
    REG_CHAIN_LEN = 2'd2,
    REG_SPARE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* src/cmcc_ram.sv */
// ----------------------------------------------------------------------------
// cmcc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cmcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/cmcc_mul.sv */
// ----------------------------------------------------------------------------
// cmcc_mul
// Multi-cycle unsigned multiplier, one 8-bit digit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module cmcc_mul
  import cmcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MA_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  output logic [PROD_W-1:0] p,
  output mul_stat_t         stat
);

  logic [MA_W-1:0]         a_r;
  logic [BR_W-1:0]         b_r;
  logic [PROD_W-1:0]       acc_r;
  logic [MCNT_W-1:0]       cnt_r;
  logic                    done_r;
  logic [MA_W+DIG_W-1:0]   pp;

  assign pp = a_r * b_r[BR_W-1 -: DIG_W];

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BR_W'(b);
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= (acc_r << DIG_W) + PROD_W'(pp);
      b_r   <= b_r << DIG_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == MCNT_W'(1)) && !start;
      if (start) begin
        cnt_r <= MCNT_W'(NDIG);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - MCNT_W'(1);
      end
    end
  end

  assign p         = acc_r;
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;

endmodule

/* src/chain_move_constraint_checker_unit.sv */
// ----------------------------------------------------------------------------
// chain_move_constraint_checker_unit
// Stores monomer positions and checks overlap, bond length and bond angle.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: index, pos_x, pos_y, pos_z; tuser: op
//   out_    | out | out_tvalid/tready  | tdata: accept, distance_ok, angle_ok
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// A write goes straight into the position RAM and leaves the unit idle. A check reads
// its own position, then the chain positions from RAM, runs them through the
// pipeline and loads its result; an interior monomer adds the dot and digit products.
// An index outside the chain skips the RAM reads and goes straight to the result load.
// Reset is synchronous; the position RAM has no clearing pass.
// A finished result waits in the output register while the next item enters.
// ----------------------------------------------------------------------------
`include "chain_move_constraint_checker_unit_assert.svh"

module chain_move_constraint_checker_unit
  import cmcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [55:0]       in_tdata,   // index[5:0], pos_x, pos_y, pos_z, zero pad
  input  logic              in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // accept, distance_ok, angle_ok, zero pad
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LOADI = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_DRAIN = 11'b00000001000,
    S_DOTP  = 11'b00000010000,
    S_DOTS  = 11'b00000100000,
    S_M0    = 11'b00001000000,
    S_M1    = 11'b00010000000,
    S_M2    = 11'b00100000000,
    S_M3    = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  function automatic logic [COORD_W-1:0] coord_fit(input logic signed [FLD_W-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[COORD_W-1:0];
  endfunction

  function automatic logic signed [DIFF_W-1:0] coord_of(input logic [POS_W-1:0] p,
                                                         input int c);
    logic signed [COORD_W-1:0] v;
    v = p[c*COORD_W +: COORD_W];
    return DIFF_W'(v);
  endfunction

  state_t state_r, state_nxt;

  logic [CUT_W-1:0]        cutoff_r;
  logic signed [COS_W-1:0] bcos_r;
  logic [LEN_W-1:0]        chain_len_r;

  logic [IDX_W-1:0]        idx_in;
  logic                    in_acc, chk_acc, wr_en, in_range;
  logic [CNT_W-1:0]        n_w;

  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        n_r;
  logic [CSQ_W-1:0]        c2_r;
  logic [BSQ_W-1:0]        bmag2_r;
  logic [COS_W-1:0]        bmag;
  logic [2*COS_W-1:0]      bsq_full;

  logic [AW-1:0]           raddr;
  logic [POS_W-1:0]        rdata, wdata, pi_r;
  logic [CNT_W-1:0]        rk_r, rk_nxt, k1_r, k1_nxt, k2_r, k3_r;
  logic                    v1_r, v1_nxt, v2_r, v3_r;

  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [DIFF_W-1:0] vec1_r [3];
  logic signed [DIFF_W-1:0] vec2_r [3];
  logic signed [DIFF_W-1:0] ma [3];
  logic signed [DIFF_W-1:0] mb [3];
  logic signed [SQ_W-1:0]   sq_nxt [3];
  logic signed [SQ_W-1:0]   sq_r [3];

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        d2u, n1_r, n2_r, dmag_r;
  logic [CMP_W-1:0]        d4, c9, c1;
  logic                    near_fail, far_fail, is_nbr, is_end;
  logic                    dot_neg, n_nz, dot_neg_r;

  logic                    dist_ok_r, ang_ok_r;
  logic [PROD_W-1:0]       lsq_r, mul_p;
  logic                    mul_start;
  logic [MA_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  mul_stat_t               mul_st;

  logic                    load_out, out_tvalid_r;
  logic [2:0]              out_data_r;

  assign idx_in    = in_tdata[5:0];
  assign in_tready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign chk_acc   = in_acc && in_tuser == OP_CHECK;
  assign wr_en     = in_acc && in_tuser == OP_WRITE && 32'(idx_in) < 32'(MAX_MONOMERS);
  assign n_w       = (32'(chain_len_r) > 32'(MAX_MONOMERS)) ? CNT_W'(MAX_MONOMERS)
                                                           : CNT_W'(chain_len_r);
  assign in_range  = 32'(idx_in) < 32'(n_w);
  assign wdata     = {coord_fit(in_tdata[53:38]), coord_fit(in_tdata[37:22]),
                      coord_fit(in_tdata[21:6])};
  assign bmag      = bcos_r[COS_W-1] ? COS_W'(-bcos_r) : COS_W'(bcos_r);
  assign bsq_full  = bmag * bmag;

  cmcc_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_MONOMERS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(idx_in)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cmcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .stat  (mul_st)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= CUT_W'(256);
      bcos_r      <= '0;
      chain_len_r <= LEN_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CUTOFF:    cutoff_r    <= cfg_data[CUT_W-1:0];
        REG_BOND_COS:  bcos_r      <= cfg_data[COS_W-1:0];
        REG_CHAIN_LEN: chain_len_r <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // arithmetic helpers
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ma[c]     = (state_r == S_DOTP) ? vec1_r[c] : d_r[c];
      mb[c]     = (state_r == S_DOTP) ? vec2_r[c] : d_r[c];
      sq_nxt[c] = ma[c] * mb[c];
    end
  end

  assign sum       = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  assign d2u       = sum;
  assign d4        = CMP_W'(d2u) << 2;
  assign c1        = CMP_W'(c2_r);
  assign c9        = (c1 << 3) + c1;
  assign is_nbr    = (32'(k3_r) + 32'd1 == 32'(idx_r)) || (32'(k3_r) == 32'(idx_r) + 32'd1);
  assign near_fail = CMP_W'(d2u) < c1;
  assign far_fail  = is_nbr && !(d4 < c9);
  assign is_end    = (idx_r == '0) || (32'(idx_r) == 32'(n_r) - 32'd1);
  assign dot_neg   = sum[SUM_W-1];
  assign n_nz      = (n1_r != '0) && (n2_r != '0);

  // control
  always_comb begin
    state_nxt = state_r;
    raddr     = AW'(idx_in);
    rk_nxt    = rk_r;
    v1_nxt    = 1'b0;
    k1_nxt    = k1_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (chk_acc) begin
          state_nxt = in_range ? S_LOADI : S_DONE;
        end
      end
      S_LOADI: begin
        raddr     = '0;
        v1_nxt    = 1'b1;
        k1_nxt    = '0;
        rk_nxt    = CNT_W'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        raddr = AW'(rk_r);
        if (rk_r < n_r) begin
          v1_nxt = 1'b1;
          k1_nxt = rk_r;
          rk_nxt = rk_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = is_end ? S_DONE : S_DOTP;
        end
      end
      S_DOTP: state_nxt = S_DOTS;
      S_DOTS: begin
        if (!n_nz || (dot_neg && !bcos_r[COS_W-1]) ||
            (!dot_neg && (bcos_r[COS_W-1] || bcos_r == '0))) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(dmag_r);
        mul_b     = MB_W'(dmag_r);
        state_nxt = S_M1;
      end
      S_M1: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = MA_W'(n1_r);
          mul_b     = MB_W'(n2_r);
          state_nxt = S_M2;
        end
      end
      S_M2: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = mul_p[MA_W-1:0];
          mul_b     = MB_W'(bmag2_r);
          state_nxt = S_M3;
        end
      end
      S_M3: begin
        if (mul_st.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rk_r <= rk_nxt;
    k1_r <= k1_nxt;
    k2_r <= k1_r;
    k3_r <= k2_r;
    if (chk_acc) begin
      idx_r     <= idx_in;
      n_r       <= n_w;
      c2_r      <= cutoff_r * cutoff_r;
      bmag2_r   <= bsq_full[BSQ_W-1:0];
      dist_ok_r <= in_range;
      ang_ok_r  <= 1'b0;
    end
    if (state_r == S_LOADI) begin
      pi_r <= rdata;
    end
    if (v1_r) begin
      for (int c = 0; c < 3; c++) begin
        d_r[c] <= coord_of(rdata, c) - coord_of(pi_r, c);
      end
    end
    if (v2_r || state_r == S_DOTP) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= sq_nxt[c];
      end
    end
    if (v2_r && 32'(k2_r) + 32'd1 == 32'(idx_r)) begin
      for (int c = 0; c < 3; c++) begin
        vec1_r[c] <= d_r[c];
      end
    end
    if (v2_r && 32'(k2_r) == 32'(idx_r) + 32'd1) begin
      for (int c = 0; c < 3; c++) begin
        vec2_r[c] <= d_r[c];
      end
    end
    if (v3_r && 32'(k3_r) != 32'(idx_r)) begin
      if (near_fail || far_fail) begin
        dist_ok_r <= 1'b0;
      end
      if (32'(k3_r) + 32'd1 == 32'(idx_r)) begin
        n1_r <= d2u;
      end
      if (32'(k3_r) == 32'(idx_r) + 32'd1) begin
        n2_r <= d2u;
      end
    end
    if (state_r == S_DRAIN && !v1_r && !v2_r && !v3_r && is_end) begin
      ang_ok_r <= 1'b1;
    end
    if (state_r == S_DOTS) begin
      ang_ok_r  <= n_nz && dot_neg && !bcos_r[COS_W-1];
      dot_neg_r <= dot_neg;
      dmag_r    <= dot_neg ? SUM_W'(-sum) : SUM_W'(sum);
    end
    if (state_r == S_M1 && mul_st.done) begin
      lsq_r <= {mul_p[PROD_W-SHL_W-1:0], {SHL_W{1'b0}}};
    end
    if (state_r == S_M3 && mul_st.done) begin
      ang_ok_r <= dot_neg_r ? (lsq_r > mul_p) : (lsq_r < mul_p);
    end
    if (load_out) begin
      out_data_r <= {ang_ok_r, dist_ok_r, dist_ok_r && ang_ok_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_data_r};

  `CMCC_ASSERT_IMPL(a_idle_mul_quiet, in_tready, !mul_st.busy)
  `CMCC_ASSERT_IMPL(a_accept_both, out_tvalid && out_tdata[0], out_tdata[1] && out_tdata[2])
  `CMCC_ASSERT_NEXT(a_out_of_chain, chk_acc && !in_range, state_r == S_DONE)
  `CMCC_ASSERT_IMPL(a_pipe_in_scan, v3_r, state_r == S_SCAN || state_r == S_DRAIN)

endmodule

/* test/tb_chain_move_constraint_checker_unit.sv */
// ----------------------------------------------------------------------------
// tb_chain_move_constraint_checker_unit
// Writes monomer positions and checks monomers through the stream port. An
// internal predictor computes each check's flags. Results are compared per
// field in order, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_chain_move_constraint_checker_unit;
  import cmcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic accept;
    logic distance_ok;
    logic angle_ok;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [55:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;

  chain_move_constraint_checker_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0]       cutoff_q;
  logic signed [15:0] cos_q;
  int                len_q;
  logic signed [15:0] mono_pos [MAX_MONOMERS][3];
  verdict_t          verdict_q [$];
  int                errors = 0;
  int                cycles = 0;
  bit                idle_in = 1'b1;
  bit                idle_out = 1'b1;
  int                hold_out = 0;

  function automatic longint dsq(int a, int b);
    longint s, d;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      d = longint'(mono_pos[a][c]) - longint'(mono_pos[b][c]);
      s += d * d;
    end
    return s;
  endfunction

  function automatic bit bend_ok(int j);
    longint v1, v2, dot, n1, n2, bm;
    logic [255:0] lhs, rhs;
    dot = 0; n1 = 0; n2 = 0;
    for (int c = 0; c < 3; c++) begin
      v1 = longint'(mono_pos[j-1][c]) - longint'(mono_pos[j][c]);
      v2 = longint'(mono_pos[j+1][c]) - longint'(mono_pos[j][c]);
      dot += v1 * v2;
      n1 += v1 * v1;
      n2 += v2 * v2;
    end
    if (n1 == 0 || n2 == 0) return 1'b0;
    if (dot < 0 && cos_q >= 0) return 1'b1;
    if (dot >= 0 && cos_q <= 0) return 1'b0;
    bm = (cos_q < 0) ? -longint'(cos_q) : longint'(cos_q);
    lhs = 256'((dot < 0) ? -dot : dot);
    lhs = (lhs * lhs) << 30;
    rhs = 256'(n1) * 256'(n2) * 256'(bm * bm);
    return (dot >= 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic verdict_t judge_monomer(int idx);
    verdict_t v;
    longint c2, d2;
    bit dok, aok;
    if (idx >= len_q) return '0;
    c2 = longint'(cutoff_q) * longint'(cutoff_q);
    dok = 1'b1;
    for (int k = 0; k < len_q; k++) begin
      if (k == idx) continue;
      d2 = dsq(idx, k);
      if (d2 < c2) dok = 1'b0;
      else if ((k + 1 == idx || k == idx + 1) && !(4 * d2 < 9 * c2)) dok = 1'b0;
    end
    aok = (idx == 0 || idx == len_q - 1) ? 1'b1 : bend_ok(idx);
    v.accept = dok & aok;
    v.distance_ok = dok;
    v.angle_ok = aok;
    return v;
  endfunction

  task automatic send_item(bit op, int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (idle_in && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, z, y, x, 6'(idx)};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      mono_pos[idx] = '{x, y, z};
    end else begin
      verdict_q.push_back(judge_monomer(idx));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      REG_CUTOFF:    cutoff_q = val;
      REG_BOND_COS:  cos_q = val;
      REG_CHAIN_LEN: len_q = (val[6:0] > MAX_MONOMERS) ? MAX_MONOMERS : int'(val[6:0]);
      default: ;
    endcase
  endtask

  // Chain along x with a given bond step and a random jitter on every axis.
  task automatic lay_chain(int step, int jitter);
    for (int i = 0; i < MAX_MONOMERS; i++)
      send_item(OP_WRITE, i, 16'(i * step - 32 * step + $urandom_range(jitter)),
                16'($urandom_range(2 * jitter)) - 16'(jitter),
                16'($urandom_range(2 * jitter)) - 16'(jitter));
  endtask

  task automatic check_any();
    send_item(OP_CHECK, $urandom_range(63), '0, '0, '0);
  endtask

  task automatic test_directed();
    lay_chain(300, 0);
    for (int i = 0; i < 4; i++) check_any();
    send_item(OP_CHECK, 0, '0, '0, '0);
    send_item(OP_CHECK, 63, '0, '0, '0);
    send_item(OP_WRITE, 5, 16'h7fff, 16'h8000, 16'hffff);
    send_item(OP_CHECK, 5, '0, '0, '0);
    send_item(OP_CHECK, 4, '0, '0, '0);
    send_item(OP_WRITE, 10, 16'(9 * 300 - 32 * 300), '0, '0);
    send_item(OP_CHECK, 10, '0, '0, '0);
    send_item(OP_CHECK, 9, '0, '0, '0);
  endtask

  task automatic test_configs();
    write_reg(REG_CUTOFF, 16'd0);
    write_reg(REG_BOND_COS, 16'h8000);
    write_reg(REG_CHAIN_LEN, 16'd3);
    for (int i = 0; i < 8; i++) check_any();
    send_item(OP_CHECK, 2, '0, '0, '0);
    write_reg(REG_CUTOFF, 16'hffff);
    write_reg(REG_BOND_COS, 16'h7fff);
    write_reg(REG_CHAIN_LEN, 16'd127);
    for (int i = 0; i < 6; i++) check_any();
    write_reg(REG_SPARE, 16'h1234);
    write_reg(REG_CUTOFF, 16'd256);
    write_reg(REG_BOND_COS, 16'd0);
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < 1500) begin
      write_reg(REG_CUTOFF, 16'($urandom_range(150, 320)));
      write_reg(REG_BOND_COS, 16'($urandom_range(65535)));
      write_reg(REG_CHAIN_LEN, 16'($urandom_range(3, 64)));
      idle_in = ($urandom_range(3) != 0);
      idle_out = ($urandom_range(3) != 0);
      lay_chain($urandom_range(200, 400), $urandom_range(1, 120));
      n += 64;
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(9) == 0)
          send_item(OP_WRITE, $urandom_range(63), 16'($urandom), 16'($urandom),
                    16'($urandom));
        else check_any();
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_out = 600;
    for (int i = 0; i < 12; i++) check_any();
  endtask

  always @(posedge clk) begin
    if (hold_out > 0) hold_out <= hold_out - 1;
    out_tready <= (hold_out <= 1) && (!idle_out || $urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    verdict_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = verdict_t'({out_tdata[0], out_tdata[1], out_tdata[2]});
      if (verdict_q.size() == 0) begin
        $error("result transaction with nothing pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got.accept !== want.accept) begin
          $error("accept exp %0b got %0b", want.accept, got.accept); errors++;
        end
        if (got.distance_ok !== want.distance_ok) begin
          $error("distance_ok exp %0b got %0b", want.distance_ok, got.distance_ok); errors++;
        end
        if (got.angle_ok !== want.angle_ok) begin
          $error("angle_ok exp %0b got %0b", want.angle_ok, got.angle_ok); errors++;
        end
      end
    end
    if (cycles > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cutoff_q = 16'd256;
    cos_q = 16'sd0;
    len_q = MAX_MONOMERS;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_configs();
    test_random();
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
